// File: rtl/spsd_pkg.sv
`default_nettype none
package spsd_pkg;

  // default image bound; positions saturate here
  localparam int unsigned MAX_PIXELS_DEF = 262144;
  // result queue depth, holds two full bytes worth of pixels
  localparam int unsigned RESQ_DEPTH_DEF = 4;

  localparam int unsigned CFG_W    = 19;
  localparam int unsigned IDX_W    = 18;
  localparam int unsigned ADV_W    = 9;   // widest skip is 15 + 17 + 240

  localparam logic [3:0] NIB_SHORT_SKIP = 4'h0e;
  localparam logic [3:0] NIB_LONG_SKIP  = 4'h0f;
  localparam logic [ADV_W-1:0] LONG_BIAS = 9'd17;

  // configuration register indexes
  localparam logic REG_PIXEL_TOTAL  = 1'b0;
  localparam logic REG_IMAGE_PIXELS = 1'b1;
  localparam logic [CFG_W-1:0] IMAGE_PIXELS_RST = 19'd228484;

  typedef enum logic [1:0] {
    MODE_CODE  = 2'd0,
    MODE_SHORT = 2'd1,
    MODE_LONGL = 2'd2,
    MODE_LONGH = 2'd3
  } mode_t;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       start_req;
  } in_t;

  typedef struct packed {
    logic [IDX_W-1:0] pixel_index;
    logic [3:0]       pixel_value;
    logic             out_of_range;
    logic             image_done;
    logic             last_of_byte;
  } out_t;

  typedef struct packed {
    logic [CFG_W-1:0] pixel_total;
    logic [CFG_W-1:0] image_pixels;
  } cfg_t;

  // decoder control state apart from the position
  typedef struct packed {
    mode_t            mode;
    logic [3:0]       skip_low;
    logic [CFG_W-1:0] pixels_done;
  } dec_ctl_t;

endpackage
`default_nettype wire

// File: rtl/sparse_pixel_skip_decoder.sv
// A taken byte is decoded from the input register; its pixels show on out_* via the queue.
// Throughput: one code byte per cycle while the result queue has room for two pixels.
// Output moves one pixel per cycle unless stalled; two-pixel bytes drain at half rate.
// Reset: synchronous, active low; clears decoder state, queue pointers, config to defaults.
// Queue payload is not cleared; it is never shown before being written.
`default_nettype none
module sparse_pixel_skip_decoder #(
  parameter int unsigned MAX_PIXELS = spsd_pkg::MAX_PIXELS_DEF
) (
  input  wire  logic                         clk,
  input  wire  logic                         rst_n,
  // input channel
  input  wire  logic                         in_valid,
  output logic                               in_stall,
  input  wire  spsd_pkg::in_t                in_data,
  // result channel
  output logic                               out_valid,
  input  wire  logic                         out_stall,
  output spsd_pkg::out_t                     out_data,
  // config write port
  input  wire  logic                         cfg_we,
  input  wire  logic                         cfg_addr,
  input  wire  logic [spsd_pkg::CFG_W-1:0]   cfg_wdata
);
  import spsd_pkg::*;

  // position holds 0..MAX_PIXELS inclusive (saturated value is MAX_PIXELS)
  localparam int unsigned PW = $clog2(MAX_PIXELS) + 1;

  // ---------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------
  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pixel_total  <= '0;
      cfg_r.image_pixels <= IMAGE_PIXELS_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_PIXEL_TOTAL:  cfg_r.pixel_total  <= cfg_wdata;
        REG_IMAGE_PIXELS: cfg_r.image_pixels <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------
  // input register: one code byte waiting to be decoded
  // ---------------------------------------------------------------
  logic in_vld_r;
  in_t  in_dat_r;
  logic room2;
  logic fire;      // decode the held byte this cycle
  logic in_take;   // input transaction completes

  assign fire     = in_vld_r && room2;
  assign in_stall = in_vld_r && !fire;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_take || (in_vld_r && !fire);
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_dat_r <= in_data;
    end
  end

  // ---------------------------------------------------------------
  // decoder state; start_req clears it ahead of the byte
  // ---------------------------------------------------------------
  dec_ctl_t      ctl_r;
  logic [PW-1:0] pos_r;
  dec_ctl_t      ctl_0;
  logic [PW-1:0] pos_0;

  always_comb begin
    ctl_0 = ctl_r;
    pos_0 = pos_r;
    if (in_dat_r.start_req) begin
      ctl_0.mode        = MODE_CODE;
      ctl_0.skip_low    = '0;
      ctl_0.pixels_done = '0;
      pos_0             = '0;
    end
  end

  // low nibble, then high nibble, chained
  dec_ctl_t      ctl_1, ctl_2;
  logic [PW-1:0] pos_1, pos_2;
  logic          emit_lo, emit_hi;
  out_t          res_lo, res_hi;

  spsd_nib #(.MAX_PIXELS(MAX_PIXELS), .PW(PW)) u_nib_lo (
    .nib     (in_dat_r.code_byte[3:0]),
    .cfg     (cfg_r),
    .ctl     (ctl_0),
    .pos     (pos_0),
    .ctl_nxt (ctl_1),
    .pos_nxt (pos_1),
    .emit    (emit_lo),
    .res     (res_lo)
  );

  spsd_nib #(.MAX_PIXELS(MAX_PIXELS), .PW(PW)) u_nib_hi (
    .nib     (in_dat_r.code_byte[7:4]),
    .cfg     (cfg_r),
    .ctl     (ctl_1),
    .pos     (pos_1),
    .ctl_nxt (ctl_2),
    .pos_nxt (pos_2),
    .emit    (emit_hi),
    .res     (res_hi)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.mode        <= MODE_CODE;
      ctl_r.skip_low    <= '0;
      ctl_r.pixels_done <= '0;
      pos_r             <= '0;
    end else if (fire) begin
      ctl_r <= ctl_2;
      pos_r <= pos_2;
    end
  end

  // ---------------------------------------------------------------
  // pack emitted pixels in order and mark the byte's last one
  // ---------------------------------------------------------------
  logic [1:0] push_cnt;
  out_t       push_d0, push_d1;

  always_comb begin
    push_cnt = 2'd0;
    push_d0  = res_hi;
    push_d1  = res_hi;
    if (fire) begin
      push_cnt = {1'b0, emit_lo} + {1'b0, emit_hi};
    end
    if (emit_lo) begin
      push_d0 = res_lo;
    end
    // single pixel: it is the last; two pixels: the second is
    push_d0.last_of_byte = !(emit_lo && emit_hi);
    push_d1.last_of_byte = 1'b1;
  end

  spsd_resq #(.DEPTH(RESQ_DEPTH_DEF)) u_resq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (push_cnt),
    .push_d0   (push_d0),
    .push_d1   (push_d1),
    .room2     (room2),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  a_pos_sat: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= PW'(MAX_PIXELS))
    else $error("position beyond saturation point");

  a_skip_no_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && ctl_0.mode != MODE_CODE) |-> !emit_lo)
    else $error("pixel emitted while a skip operand was expected");

endmodule
`default_nettype wire

// File: rtl/spsd_nib.sv
`default_nettype none
// One nibble decode step: skip/code handling, position advance, pixel result.
module spsd_nib #(
  parameter int unsigned MAX_PIXELS = spsd_pkg::MAX_PIXELS_DEF,
  parameter int unsigned PW         = $clog2(MAX_PIXELS) + 1
) (
  input  wire  logic [3:0]          nib,
  input  wire  spsd_pkg::cfg_t      cfg,
  input  wire  spsd_pkg::dec_ctl_t  ctl,
  input  wire  logic [PW-1:0]       pos,
  output spsd_pkg::dec_ctl_t        ctl_nxt,
  output logic [PW-1:0]             pos_nxt,
  output logic                      emit,
  output spsd_pkg::out_t            res
);
  import spsd_pkg::*;

  localparam int unsigned SW = ((PW > ADV_W) ? PW : ADV_W) + 1;
  localparam int unsigned CW = (PW > CFG_W) ? PW : CFG_W;
  localparam int unsigned IW = (PW > IDX_W) ? PW : IDX_W;
  localparam logic [SW-1:0] MAX_S = SW'(MAX_PIXELS);
  localparam logic [PW-1:0] MAX_P = PW'(MAX_PIXELS);

  logic             active;
  logic             adv;
  logic [ADV_W-1:0] amount;
  logic [SW-1:0]    pos_sum;
  logic [PW-1:0]    idx;
  logic [IW-1:0]    idx_w;
  mode_t            mode_nxt;
  logic [3:0]       skip_nxt;

  assign active = ctl.pixels_done < cfg.pixel_total;

  // next mode
  always_comb begin
    mode_nxt = ctl.mode;
    if (active) begin
      unique case (ctl.mode)
        MODE_CODE: begin
          if (nib == NIB_SHORT_SKIP) begin
            mode_nxt = MODE_SHORT;
          end else if (nib == NIB_LONG_SKIP) begin
            mode_nxt = MODE_LONGL;
          end
        end
        MODE_SHORT: mode_nxt = MODE_CODE;
        MODE_LONGL: mode_nxt = MODE_LONGH;
        MODE_LONGH: mode_nxt = MODE_CODE;
        default:    mode_nxt = MODE_CODE;
      endcase
    end
  end

  // outputs of the step
  always_comb begin
    emit     = 1'b0;
    adv      = 1'b0;
    amount   = '0;
    skip_nxt = ctl.skip_low;
    if (active) begin
      unique case (ctl.mode)
        MODE_CODE: begin
          if (nib != NIB_SHORT_SKIP && nib != NIB_LONG_SKIP) begin
            emit   = 1'b1;
            adv    = 1'b1;
            amount = ADV_W'(1);
          end
        end
        MODE_SHORT: begin
          adv    = 1'b1;
          amount = ADV_W'(nib) + ADV_W'(1);
        end
        MODE_LONGL: skip_nxt = nib;
        MODE_LONGH: begin
          adv    = 1'b1;
          amount = ADV_W'(ctl.skip_low) + LONG_BIAS + {1'b0, nib, 4'b0000};
        end
        default: ;
      endcase
    end
  end

  assign ctl_nxt = {mode_nxt, skip_nxt, ctl.pixels_done + CFG_W'(emit)};

  // saturating advance
  assign pos_sum = SW'(pos) + SW'(amount);
  always_comb begin
    pos_nxt = pos;
    if (adv) begin
      pos_nxt = (pos_sum >= MAX_S) ? MAX_P : pos_sum[PW-1:0];
    end
  end

  assign idx   = (pos >= MAX_P) ? (MAX_P - PW'(1)) : pos;
  assign idx_w = IW'(idx);

  assign res.pixel_index  = idx_w[IDX_W-1:0];
  assign res.pixel_value  = nib + 4'd1;
  assign res.out_of_range = CW'(pos) >= CW'(cfg.image_pixels);
  assign res.image_done   = (ctl.pixels_done + CFG_W'(1)) == cfg.pixel_total;
  assign res.last_of_byte = 1'b0;

endmodule
`default_nettype wire

// File: rtl/spsd_resq.sv
`default_nettype none
// Result queue: takes up to two pixels a cycle, gives one per transaction.
module spsd_resq #(
  parameter int unsigned DEPTH = spsd_pkg::RESQ_DEPTH_DEF
) (
  input  wire  logic            clk,
  input  wire  logic            rst_n,
  input  wire  logic [1:0]      push_cnt,
  input  wire  spsd_pkg::out_t  push_d0,
  input  wire  spsd_pkg::out_t  push_d1,
  output logic                  room2,
  output logic                  out_valid,
  input  wire  logic            out_stall,
  output spsd_pkg::out_t        out_data
);
  import spsd_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  out_t           mem_r [DEPTH];
  logic [AW-1:0]  head_r, head_nxt;
  logic [AW-1:0]  tail_r, tail_nxt;
  logic [AW-1:0]  tail1;
  logic [CNW-1:0] cnt_r, cnt_nxt;
  logic           pop;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
    return (p == LAST) ? '0 : p + AW'(1);
  endfunction

  assign tail1     = wrap_inc(tail_r);
  assign out_valid = cnt_r != '0;
  assign out_data  = mem_r[head_r];
  assign pop       = out_valid && !out_stall;
  assign room2     = cnt_r <= CNW'(DEPTH - 2);

  always_comb begin
    head_nxt = pop ? wrap_inc(head_r) : head_r;
    tail_nxt = tail_r;
    if (push_cnt == 2'd1) begin
      tail_nxt = tail1;
    end else if (push_cnt == 2'd2) begin
      tail_nxt = wrap_inc(tail1);
    end
    cnt_nxt = cnt_r + CNW'(push_cnt) - CNW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem_r[tail_r] <= push_d0;
    end
    if (push_cnt == 2'd2) begin
      mem_r[tail1] <= push_d1;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNW'(DEPTH))
    else $error("result queue count beyond depth");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (push_cnt != 2'd0) |-> (cnt_r + CNW'(push_cnt) <= CNW'(DEPTH)))
    else $error("result queue written past its depth");

endmodule
`default_nettype wire
